@@ design/lrui_pkg.sv @@
// ----------------------------------------------------------------------------
// lrui_pkg: shared types and constants for the LRU-insert replacement block
// Geometry of the cache, the per-set row layouts held in the memories and
// the request codes.
// ----------------------------------------------------------------------------
package lrui_pkg;

	// Cache geometry; SETS is a power of two so a set index is the low bits
	localparam int WAYS         = 8;
	localparam int SETS         = 64;
	localparam int OFFSET_BITS  = 6;
	localparam int ADDRESS_BITS = 48;

	localparam int WAY_W = $clog2(WAYS);
	localparam int AGE_W = $clog2(WAYS);
	localparam int SET_W = $clog2(SETS);
	localparam int TAG_W = ADDRESS_BITS - OFFSET_BITS;

	// Request codes on the mode field
	typedef enum logic [1:0] {
		MODE_VICTIM = 2'd0,
		MODE_UPDATE = 2'd1,
		MODE_INSERT = 2'd2
	} mode_t;

	// Sequencing states of the core: wait for an item, search, write back
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPD
	} fsm_state_t;

	typedef logic [AGE_W-1:0] age_t;
	typedef logic [TAG_W-1:0] tag_t;

	// One set's replacement row: valid bits and ages of all ways
	typedef struct packed {
		logic [WAYS-1:0] valid;
		age_t [WAYS-1:0] age;
	} meta_t;

	typedef tag_t [WAYS-1:0] tag_row_t;

	// Write-back request into the set store
	typedef struct packed {
		logic             en;
		logic [SET_W-1:0] set_idx;
		meta_t            meta;
		tag_row_t         tags;
	} store_wr_t;

	// Result of searching one set
	typedef struct packed {
		logic             present;
		logic [WAY_W-1:0] hit_way;
		logic [WAY_W-1:0] victim;
	} lookup_t;

	// Row value of a set that was never written since reset
	function automatic meta_t meta_reset();
		meta_t m;
		m.valid = '0;
		for (int w = 0; w < WAYS; w++) begin
			m.age[w] = AGE_W'(w);
		end
		return m;
	endfunction

endpackage

@@ design/lrui_store.sv @@
// ----------------------------------------------------------------------------
// lrui_store: per-set storage for ages, valid bits and tags
// Two synchronous memories with registered read. A flag per set marks rows
// written since reset; an unwritten row reads as the reset row.
// ----------------------------------------------------------------------------
module lrui_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [lrui_pkg::SET_W-1:0] rd_set,
	input  lrui_pkg::store_wr_t       wr,
	output lrui_pkg::meta_t           rd_meta,
	output lrui_pkg::tag_row_t        rd_tags
);

	lrui_pkg::meta_t    meta_mem [lrui_pkg::SETS];
	lrui_pkg::tag_row_t tag_mem  [lrui_pkg::SETS];

	logic [lrui_pkg::SETS-1:0] row_init_q;
	logic                      rd_init_q;
	lrui_pkg::meta_t           meta_raw_q;
	lrui_pkg::tag_row_t        tags_q;

	// Write a full row, read a full row
	always_ff @(posedge clk) begin
		if (wr.en) begin
			meta_mem[wr.set_idx] <= wr.meta;
			tag_mem[wr.set_idx]  <= wr.tags;
		end
		if (rd_en) begin
			meta_raw_q <= meta_mem[rd_set];
			tags_q     <= tag_mem[rd_set];
		end
	end

	// Track which rows hold written data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
			rd_init_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				row_init_q[wr.set_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_init_q <= row_init_q[rd_set];
			end
		end
	end

	// Substitute the reset row for sets never written
	assign rd_meta = rd_init_q ? meta_raw_q : lrui_pkg::meta_reset();
	assign rd_tags = tags_q;

endmodule

@@ design/lrui_lookup.sv @@
// ----------------------------------------------------------------------------
// lrui_lookup: tag search and victim choice over one set
// Finds the first valid way holding the tag, and the victim: the first
// invalid way, otherwise the oldest way (lowest way on equal ages).
// ----------------------------------------------------------------------------
module lrui_lookup (
	input  lrui_pkg::meta_t    meta,
	input  lrui_pkg::tag_row_t tags,
	input  lrui_pkg::tag_t     tag,
	output lrui_pkg::lookup_t  res
);

	logic                        any_invalid;
	logic [lrui_pkg::WAY_W-1:0]  first_invalid;
	logic [lrui_pkg::WAY_W-1:0]  oldest_way;
	lrui_pkg::age_t              oldest_age;

	// Search the tags, lowest matching way first
	always_comb begin
		res.present = 1'b0;
		res.hit_way = '0;
		for (int w = lrui_pkg::WAYS - 1; w >= 0; w--) begin
			if (meta.valid[w] && tags[w] == tag) begin
				res.present = 1'b1;
				res.hit_way = lrui_pkg::WAY_W'(w);
			end
		end
	end

	// Pick the first invalid way
	always_comb begin
		any_invalid   = 1'b0;
		first_invalid = '0;
		for (int w = lrui_pkg::WAYS - 1; w >= 0; w--) begin
			if (!meta.valid[w]) begin
				any_invalid   = 1'b1;
				first_invalid = lrui_pkg::WAY_W'(w);
			end
		end
	end

	// Pick the oldest way, keeping the lower way on a tie
	always_comb begin
		oldest_way = '0;
		oldest_age = meta.age[0];
		for (int w = 1; w < lrui_pkg::WAYS; w++) begin
			if (meta.age[w] > oldest_age) begin
				oldest_way = lrui_pkg::WAY_W'(w);
				oldest_age = meta.age[w];
			end
		end
	end

	assign res.victim = any_invalid ? first_invalid : oldest_way;

endmodule

@@ design/lru_replacement_with_lru_insert_core.sv @@
// ----------------------------------------------------------------------------
// lru_replacement_with_lru_insert_core: true-LRU replacement with LRU insert
// Victim search, access update and insert-at-LRU over per-set age rows.
// ----------------------------------------------------------------------------
// Each item passes through the states in order: ST_IDLE accepts it and
// starts the set read, ST_LOOK searches the set, and ST_UPD applies the age
// change, writes the set row back and loads the result register. One item
// is in flight at a time, so the read of an item never meets the write of
// the one before it. A result held by a stalled consumer holds the final
// step; a new item is taken once the write-back is done.
// After reset every set reads as ages equal to way number and no valid line,
// with no clearing pass.
module lru_replacement_with_lru_insert_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       mode,
	input  logic [5:0]                       set_index,
	input  logic [2:0]                       way,
	input  logic [lrui_pkg::ADDRESS_BITS-1:0] address,
	input  logic                             is_writeback,
	input  logic                             hit,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       chosen_way,
	output logic                             was_present
);

	lrui_pkg::fsm_state_t state_q, state_d;

	logic                       accept;
	logic                       advance;
	lrui_pkg::tag_t             in_tag;

	logic [1:0]                 mode_q;
	logic [lrui_pkg::SET_W-1:0] set_q;
	logic [lrui_pkg::WAY_W-1:0] way_q;
	lrui_pkg::tag_t             tag_q;
	logic                       wb_q;
	logic                       hit_q;

	logic [lrui_pkg::WAY_W-1:0] tw_q, tw_d;
	logic                       present_q, present_d;
	logic                       fill_q, fill_d;
	logic                       touch_q, touch_d;
	logic                       demote_q, demote_d;

	lrui_pkg::meta_t            rd_meta;
	lrui_pkg::tag_row_t         rd_tags;
	lrui_pkg::lookup_t          look;
	lrui_pkg::meta_t            new_meta;
	lrui_pkg::tag_row_t         new_tags;
	lrui_pkg::store_wr_t        wr;
	lrui_pkg::age_t             cur_age;

	logic                       out_valid_q;
	logic [lrui_pkg::WAY_W-1:0] chosen_q;
	logic                       present_out_q;

	assign in_tag  = address[lrui_pkg::ADDRESS_BITS-1:lrui_pkg::OFFSET_BITS];
	assign accept  = in_valid && in_ready;
	assign advance = (state_q == lrui_pkg::ST_UPD) && (!out_valid_q || out_ready);

	// Hold the set rows
	lrui_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_set ((mode == lrui_pkg::MODE_INSERT) ?
			in_tag[lrui_pkg::SET_W-1:0] : set_index[lrui_pkg::SET_W-1:0]),
		.wr     (wr),
		.rd_meta(rd_meta),
		.rd_tags(rd_tags)
	);

	// Search the set read for this item
	lrui_lookup u_lookup (
		.meta(rd_meta),
		.tags(rd_tags),
		.tag (tag_q),
		.res (look)
	);

	// Sequence the item through read, search and write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrui_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			lrui_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = lrui_pkg::ST_LOOK;
				end
			end
			lrui_pkg::ST_LOOK: begin
				state_d = lrui_pkg::ST_UPD;
			end
			lrui_pkg::ST_UPD: begin
				if (advance) begin
					state_d = lrui_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lrui_pkg::ST_IDLE;
			end
		endcase
	end

	// Capture the request fields
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			set_q  <= (mode == lrui_pkg::MODE_INSERT) ?
				in_tag[lrui_pkg::SET_W-1:0] : set_index[lrui_pkg::SET_W-1:0];
			way_q  <= way[lrui_pkg::WAY_W-1:0];
			tag_q  <= in_tag;
			wb_q   <= is_writeback;
			hit_q  <= hit;
		end
	end

	// Decide the target way and what changes in the set
	always_comb begin
		tw_d      = '0;
		present_d = 1'b0;
		fill_d    = 1'b0;
		touch_d   = 1'b0;
		demote_d  = 1'b0;
		case (mode_q)
			lrui_pkg::MODE_VICTIM: begin
				tw_d = look.victim;
			end
			lrui_pkg::MODE_UPDATE: begin
				tw_d    = way_q;
				touch_d = !(wb_q && hit_q);
				fill_d  = !hit_q;
			end
			lrui_pkg::MODE_INSERT: begin
				present_d = look.present;
				tw_d      = look.present ? look.hit_way : look.victim;
				fill_d    = !look.present;
				touch_d   = 1'b1;
				demote_d  = 1'b1;
			end
			default: begin
				tw_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == lrui_pkg::ST_LOOK) begin
			tw_q      <= tw_d;
			present_q <= present_d;
			fill_q    <= fill_d;
			touch_q   <= touch_d;
			demote_q  <= demote_d;
		end
	end

	// Promote or demote the target way and shift the others by one
	always_comb begin
		cur_age  = rd_meta.age[tw_q];
		new_meta = rd_meta;
		new_tags = rd_tags;
		for (int w = 0; w < lrui_pkg::WAYS; w++) begin
			if (demote_q) begin
				if (rd_meta.age[w] > cur_age) begin
					new_meta.age[w] = rd_meta.age[w] - 1'b1;
				end
			end else begin
				if (rd_meta.age[w] < cur_age) begin
					new_meta.age[w] = rd_meta.age[w] + 1'b1;
				end
			end
		end
		new_meta.age[tw_q] = demote_q ? lrui_pkg::AGE_W'(lrui_pkg::WAYS - 1) : '0;
		if (fill_q) begin
			new_meta.valid[tw_q] = 1'b1;
			new_tags[tw_q]       = tag_q;
		end
	end

	assign wr.en      = advance && touch_q;
	assign wr.set_idx = set_q;
	assign wr.meta    = new_meta;
	assign wr.tags    = new_tags;

	// Load the result register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			chosen_q      <= tw_q;
			present_out_q <= present_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign chosen_way  = 3'(chosen_q);
	assign was_present = present_out_q;

	// Mark every age value that the written row holds
	logic [lrui_pkg::WAYS-1:0] age_seen;
	always_comb begin
		age_seen = '0;
		for (int w = 0; w < lrui_pkg::WAYS; w++) begin
			age_seen[new_meta.age[w]] = 1'b1;
		end
	end

	// A written row keeps its ages a permutation of all ages
	assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (&age_seen))
	else $error("set row written with a repeated age");

	// An accepted item starts its search in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == lrui_pkg::ST_LOOK))
	else $error("accepted item did not start its search");

	// Only insert reports a present line
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lrui_pkg::ST_UPD && present_q) |-> (mode_q == lrui_pkg::MODE_INSERT))
	else $error("present flag raised outside insert");

	// The set store is written only as an item completes
	assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> (state_q == lrui_pkg::ST_IDLE && out_valid_q))
	else $error("set write not followed by a result");

endmodule

@@ tb/lru_replacement_with_lru_insert_core_test.sv @@
// ----------------------------------------------------------------------------
// lru_replacement_with_lru_insert_core_test: self-checking bench for the core
// Runs a short directed table and then about 1200 random items of victim,
// update, insert and unused-mode requests. Both channels idle at random, and
// the result side once holds off long enough to back up the input. Every
// result is checked against a cycle-free model of the per-set age, valid and
// tag state, or against the typed result of a directed row.
// ----------------------------------------------------------------------------
module lru_replacement_with_lru_insert_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	import lrui_pkg::*;

	// Mode code that the package leaves unnamed; the block answers it with zeros
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS   = 1200;
	localparam int POOL_SIZE      = 32;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 10;

	typedef struct packed {
		logic [1:0]              mode;
		logic [SET_W-1:0]        set_index;
		logic [WAY_W-1:0]        way;
		logic [ADDRESS_BITS-1:0] address;
		logic                    wb;
		logic                    hit;
	} lru_req_t;

	typedef struct packed {
		logic [WAY_W-1:0] way;
		logic             present;
	} lru_result_t;

	typedef struct packed {
		lru_req_t    req;
		logic        typed;
		lru_result_t res;
	} dir_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [1:0]              mode = MODE_VICTIM;
	logic [5:0]              set_index = '0;
	logic [2:0]              way = '0;
	logic [ADDRESS_BITS-1:0] address = '0;
	logic                    is_writeback = 1'b0;
	logic                    hit = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [2:0]              chosen_way;
	logic                    was_present;

	// Shadow copy of the replacement state
	age_t age_mem   [SETS][WAYS];
	logic valid_mem [SETS][WAYS];
	tag_t tag_mem   [SETS][WAYS];

	lru_result_t             pending_results[$];
	lru_result_t             oldest_exp;
	logic [ADDRESS_BITS-1:0] addr_pool[POOL_SIZE];
	dir_row_t                dir_rows[$];
	int                      errors = 0;
	int                      idle_cycles = 0;
	bit                      quiet = 1'b0;
	bit                      hold_wanted = 1'b0;

	lru_replacement_with_lru_insert_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.set_index   (set_index),
		.way         (way),
		.address     (address),
		.is_writeback(is_writeback),
		.hit         (hit),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.chosen_way  (chosen_way),
		.was_present (was_present)
	);

	always #5 clk = ~clk;

	// First invalid way, otherwise the oldest way (lowest way on ties)
	function automatic int victim_way(int s);
		int best = 0;
		for (int w = 0; w < WAYS; w++) begin
			if (!valid_mem[s][w])
				return w;
		end
		for (int w = 1; w < WAYS; w++) begin
			if (age_mem[s][w] > age_mem[s][best])
				best = w;
		end
		return best;
	endfunction

	// Make a way newest; younger lines age by one
	function automatic void promote_line(int s, int w);
		age_t cur = age_mem[s][w];
		for (int i = 0; i < WAYS; i++) begin
			if (age_mem[s][i] < cur)
				age_mem[s][i] = age_mem[s][i] + 1'b1;
		end
		age_mem[s][w] = '0;
	endfunction

	// Make a way oldest; older lines move one step newer
	function automatic void demote_line(int s, int w);
		age_t cur = age_mem[s][w];
		for (int i = 0; i < WAYS; i++) begin
			if (age_mem[s][i] > cur)
				age_mem[s][i] = age_mem[s][i] - 1'b1;
		end
		age_mem[s][w] = AGE_W'(WAYS - 1);
	endfunction

	// Apply one request to the shadow state and return its result
	function automatic lru_result_t predict_replacement(lru_req_t r);
		lru_result_t res;
		int          s;
		int          tw;
		tag_t        t;
		res = '0;
		s = r.set_index;
		t = r.address[ADDRESS_BITS-1:OFFSET_BITS];
		case (r.mode)
			MODE_VICTIM: begin
				res.way = WAY_W'(victim_way(s));
			end
			MODE_UPDATE: begin
				res.way = r.way;
				if (!(r.wb && r.hit)) begin
					if (!r.hit) begin
						valid_mem[s][r.way] = 1'b1;
						tag_mem[s][r.way] = t;
					end
					promote_line(s, r.way);
				end
			end
			MODE_INSERT: begin
				s = int'(t[SET_W-1:0]);
				tw = WAYS;
				for (int i = 0; i < WAYS; i++) begin
					if (tw == WAYS && valid_mem[s][i] && tag_mem[s][i] == t)
						tw = i;
				end
				if (tw < WAYS) begin
					res.present = 1'b1;
				end else begin
					tw = victim_way(s);
					valid_mem[s][tw] = 1'b1;
					tag_mem[s][tw] = t;
				end
				demote_line(s, tw);
				res.way = WAY_W'(tw);
			end
			default: ;
		endcase
		return res;
	endfunction

	// Mostly cache-like traffic on a few hot sets, with some noise
	function automatic lru_req_t random_req();
		lru_req_t                r;
		logic [ADDRESS_BITS-1:0] a;
		int                      roll;
		r.mode = MODE_UNUSED;
		r.set_index = SET_W'($urandom);
		r.way = WAY_W'($urandom);
		r.address = ADDRESS_BITS'({$urandom, $urandom});
		r.wb = 1'($urandom);
		r.hit = 1'($urandom);
		a = addr_pool[$urandom_range(POOL_SIZE - 1)];
		roll = $urandom_range(99);
		if (roll < 30) begin
			r.mode = MODE_INSERT;
			if ($urandom_range(9) != 0)
				r.address = a;
		end else if (roll < 50) begin
			r.mode = MODE_VICTIM;
			if ($urandom_range(4) != 0)
				r.set_index = a[OFFSET_BITS +: SET_W];
		end else if (roll < 70) begin
			// miss fill, usually into the way a victim request would name
			r.mode = MODE_UPDATE;
			r.hit = 1'b0;
			r.address = a;
			r.set_index = a[OFFSET_BITS +: SET_W];
			if ($urandom_range(4) != 0)
				r.way = WAY_W'(victim_way(r.set_index));
		end else if (roll < 94) begin
			r.mode = MODE_UPDATE;
			r.hit = 1'b1;
			if ($urandom_range(4) != 0)
				r.set_index = a[OFFSET_BITS +: SET_W];
		end
		return r;
	endfunction

	function automatic dir_row_t row(logic [1:0] m, int s, int w, logic [ADDRESS_BITS-1:0] a,
			bit wb, bit h, bit typed, int exp_way, bit exp_present);
		dir_row_t d;
		d.req.mode = m;
		d.req.set_index = SET_W'(s);
		d.req.way = WAY_W'(w);
		d.req.address = a;
		d.req.wb = wb;
		d.req.hit = h;
		d.typed = typed;
		d.res.way = WAY_W'(exp_way);
		d.res.present = exp_present;
		return d;
	endfunction

	// Offer one item, hold it until accepted, then log its expected result
	task automatic offer(input lru_req_t r, input bit typed, input lru_result_t typed_res);
		lru_result_t p;
		while (!quiet && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= r.mode;
		set_index <= r.set_index;
		way <= r.way;
		address <= r.address;
		is_writeback <= r.wb;
		hit <= r.hit;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		p = predict_replacement(r);
		pending_results.push_back(typed ? typed_res : p);
	endtask

	// Stimulus: reset, directed table, random traffic, drain and verdict
	initial begin : stimulus
		logic [SET_W-1:0]        hot_sets[4];
		logic [ADDRESS_BITS-1:0] ones;
		lru_req_t                r;
		ones = '1;
		for (int s = 0; s < SETS; s++) begin
			for (int w = 0; w < WAYS; w++) begin
				age_mem[s][w] = AGE_W'(w);
				valid_mem[s][w] = 1'b0;
				tag_mem[s][w] = '0;
			end
		end
		for (int i = 0; i < 4; i++)
			hot_sets[i] = SET_W'($urandom);
		for (int i = 0; i < POOL_SIZE; i++)
			addr_pool[i] = {36'({$urandom, $urandom}), hot_sets[i % 4], 6'($urandom)};

		// Directed rows; typed results only where they follow at a glance
		dir_rows.push_back(row(MODE_VICTIM, 0, 0, '0, 0, 0, 1, 0, 0));
		dir_rows.push_back(row(MODE_VICTIM, 63, 7, ones, 1, 1, 1, 0, 0));
		dir_rows.push_back(row(MODE_UNUSED, 63, 7, ones, 1, 1, 1, 0, 0));
		dir_rows.push_back(row(MODE_UPDATE, 0, 7, ones, 1, 1, 1, 7, 0));
		dir_rows.push_back(row(MODE_UPDATE, 0, 0, ones, 0, 0, 1, 0, 0));
		dir_rows.push_back(row(MODE_UPDATE, 0, 7, '0, 0, 0, 1, 7, 0));
		dir_rows.push_back(row(MODE_VICTIM, 0, 0, '0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(MODE_INSERT, 0, 0, '0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(MODE_INSERT, 0, 0, ones, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(MODE_INSERT, 0, 0, ones, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(MODE_UPDATE, 63, 5, '0, 0, 1, 1, 5, 0));
		dir_rows.push_back(row(MODE_UPDATE, 0, 3, 48'hFC0, 1, 0, 1, 3, 0));
		for (int w = 0; w < WAYS; w++)
			dir_rows.push_back(row(MODE_UPDATE, 2, w, {36'(w + 1), 6'd2, 6'd0}, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(MODE_VICTIM, 2, 0, '0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(MODE_INSERT, 0, 0, {36'h123, 6'd2, 6'd5}, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(MODE_INSERT, 0, 0, {36'd5, 6'd2, 6'd63}, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(MODE_VICTIM, 2, 0, '0, 0, 0, 0, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 200)
				hold_wanted = 1'b1;
			quiet = (n >= 600 && n < 800);
			r = random_req();
			offer(r, 1'b0, '0);
		end
		in_valid <= 1'b0;
		quiet = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin : receiver
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_wanted) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_wanted = 1'b0;
			end else begin
				out_ready <= (quiet || $urandom_range(99) >= 35);
			end
		end
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: chosen_way %0d was_present %0b",
					$time, chosen_way, was_present);
				errors++;
			end else begin
				oldest_exp = pending_results.pop_front();
				if (chosen_way !== oldest_exp.way) begin
					$display("%0t: chosen_way expected %0d actual %0d",
						$time, oldest_exp.way, chosen_way);
					errors++;
				end
				if (was_present !== oldest_exp.present) begin
					$display("%0t: was_present expected %0b actual %0b",
						$time, oldest_exp.present, was_present);
					errors++;
				end
			end
		end
	end

	// Watchdog: end the run if no item moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout, no item moved for %0d cycles", $time, idle_cycles);
			$display("status: fail");
			$finish;
		end
	end

endmodule

@@ sim.f @@
design/lrui_pkg.sv
design/lrui_store.sv
design/lrui_lookup.sv
design/lru_replacement_with_lru_insert_core.sv
tb/lru_replacement_with_lru_insert_core_test.sv
